@@ sv/mpe_pkg.sv @@
// Shared constants and types for the maglev position estimator.
`timescale 1ns / 1ps

package mpe_pkg;

    // FIR length and the storage that follows from it
    localparam int TAP_COUNT  = 8;
    localparam int HIST_AW    = $clog2(TAP_COUNT);
    localparam int HIST_DEPTH = 2 ** HIST_AW;
    localparam int K_W        = $clog2(TAP_COUNT + 2);
    localparam int LAST_K     = TAP_COUNT + 1;
    localparam int ACC_W      = 34 + $clog2(TAP_COUNT);

    // Coefficient register file
    localparam int COEF_REGS = 8;
    localparam int COEF_AW   = $clog2(COEF_REGS);
    localparam int CFG_IDX_W = 8;
    localparam logic signed [15:0] COEF_RESET = 16'sd4096;

    // floor(x / 81) for 0 <= x < 2^28: (x * RECIP_81) >> 35, exact over that range
    localparam logic [28:0] RECIP_81    = 29'd424194301;
    localparam int          SHIFT_81    = 35;
    // 81 * 2^20, lifts mean*50 to a non-negative dividend
    localparam logic signed [28:0] BIAS_81 = 29'sd84934656;

    // floor(x / 2125) for 0 <= x < 2^30: (x * RECIP_2125) >> 42, exact over that range
    localparam logic [30:0] RECIP_2125  = 31'd2069668947;
    localparam int          SHIFT_2125  = 42;
    // 2125 * 2^17 - 775 * 4096 * 256 / 5
    localparam logic [29:0] BIAS_2125   = 30'd115998720;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SCALE = 9'b000000010,
        S_MUL81 = 9'b000000100,
        S_SLOPE = 9'b000001000,
        S_NUMER = 9'b000010000,
        S_MUL2  = 9'b000100000,
        S_RAW   = 9'b001000000,
        S_FIR   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

endpackage

@@ sv/maglev_position_estimator.sv @@
// Maglev gap estimator: sample scaling, derivative, raw gap and FIR smoothing.
//
// Input channel: i_in_valid / o_in_stall carry one Hall voltage sample (Q3.12)
// per transaction. Output channel: o_out_valid / i_out_stall carry one result
// transaction per sample: coil current, running mean, derivative, raw gap and
// FIR-filtered gap. Config channel: i_cfg_valid / o_cfg_ready write the eight
// Q1.15 tap coefficients by index; indexes past the last tap are dropped.
// Write coefficients only while no sample is in flight.
// One sample is processed at a time: a new sample is taken only once the
// result of the last one has moved to the output register. The FIR loop
// reads one coefficient and one history entry per cycle from two memories,
// registers both reads, then the product, then the accumulated sum.
// The finished result sits in an output register; the next sample is taken
// while it waits. If the receiver stalls and the register is still full when
// the next result is ready, the block holds that result and stalls its input.
// Reset (synchronous, active low) restores every coefficient to 4096 (0.125),
// clears the previous sample, the running mean and the gap history.
`timescale 1ns / 1ps

module maglev_position_estimator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [15:0]             i_sensor_volts,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [20:0]             o_coil_current,
    output logic signed [20:0]             o_mean_current,
    output logic signed [31:0]             o_slope_value,
    output logic signed [17:0]             o_raw_position,
    output logic signed [19:0]             o_filtered_position,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mpe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);
    import mpe_pkg::*;

    t_state r_state, n_state;

    // Control
    logic [K_W-1:0]     r_k;
    logic [HIST_AW-1:0] r_wptr;
    logic               r_rd_vld;
    logic               r_mul_vld;
    logic               r_out_valid, n_out_valid;
    logic               in_take;
    logic               out_load;

    // Carried state
    logic signed [15:0] r_last;
    logic signed [20:0] r_run_mean;

    // Datapath
    logic signed [20:0] r_cur;
    logic signed [16:0] r_diff;
    logic [27:0]        r_b81;
    logic signed [33:0] r_dterm;
    logic [56:0]        r_p81;
    logic signed [31:0] r_slope;
    logic [29:0]        r_b2;
    logic [60:0]        r_p2;
    logic signed [17:0] r_raw;
    logic signed [33:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;

    // Memories and their valid bits
    logic signed [15:0] r_coef_mem [COEF_REGS];
    logic [COEF_REGS-1:0]  r_coef_set;
    logic signed [15:0] r_coef_rd;
    logic               r_coef_ok;
    logic signed [17:0] r_hist_mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] r_hist_set;
    logic signed [17:0] r_hist_rd;
    logic               r_hist_ok;

    logic               cfg_we;
    logic [COEF_AW-1:0] cfg_addr;
    logic [COEF_AW-1:0] coef_addr;
    logic [HIST_AW-1:0] hist_addr;
    logic               fir_issue;
    logic               hist_we;

    // Combinational helpers
    logic signed [20:0] cur_w;
    logic signed [21:0] mean_sum;
    logic signed [28:0] mean_x50;
    logic signed [28:0] b81_sum;
    logic signed [22:0] q81_s;
    logic signed [34:0] slope_sum;
    logic [31:0]        slope_mag;
    logic [19:0]        mag_clip;
    logic signed [19:0] raw_pre;
    logic signed [17:0] raw_clamp;
    logic signed [15:0] coef_op;
    logic signed [17:0] hist_op;
    logic [ACC_W-1:34]  acc_hi;
    logic signed [19:0] filt_w;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;

    assign in_take  = i_in_valid && (r_state == S_IDLE);
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    assign cfg_we   = i_cfg_valid && (i_cfg_index < CFG_IDX_W'(COEF_REGS));
    assign cfg_addr = COEF_AW'(i_cfg_index);

    assign fir_issue = (r_state == S_FIR) && (r_k < K_W'(TAP_COUNT));
    assign coef_addr = COEF_AW'(r_k);
    assign hist_addr = r_wptr - HIST_AW'(r_k);
    assign hist_we   = (r_state == S_RAW);

    // Sample stage arithmetic
    assign cur_w    = $signed({{5{i_sensor_volts[15]}}, i_sensor_volts}) * 21'sd20;
    assign mean_sum = {cur_w[20], cur_w} + {r_run_mean[20], r_run_mean};

    assign mean_x50 = $signed({{8{r_run_mean[20]}}, r_run_mean}) * 29'sd50;
    assign b81_sum  = mean_x50 + BIAS_81;

    // Quotient by 81 lies below 2^21; remove the 2^20 bias
    assign q81_s     = $signed({1'b0, r_p81[SHIFT_81+21:SHIFT_81]}) - 23'sd1048576;
    assign slope_sum = {r_dterm[33], r_dterm} + {{12{q81_s[22]}}, q81_s};

    assign slope_mag = r_slope[31] ? (~r_slope + 32'd1) : r_slope;
    // Anything at or above 2^19 already drives the gap past its ceiling
    assign mag_clip  = (|slope_mag[31:19]) ? 20'd524288 : {1'b0, slope_mag[18:0]};

    assign raw_pre = $signed({1'b0, r_p2[SHIFT_2125+18:SHIFT_2125]}) - 20'sd131072;
    // clamp the gap at the top of its field; no lower limit applies
    assign raw_clamp = (raw_pre > 20'sd131071) ? 18'sd131071 : raw_pre[17:0];

    // Unwritten entries read as their reset values
    assign coef_op = r_coef_ok ? r_coef_rd : COEF_RESET;
    assign hist_op = r_hist_ok ? r_hist_rd : 18'sd0;

    assign acc_hi = r_acc[ACC_W-1:34];
    always_comb begin
        if ((&acc_hi) || !(|acc_hi)) begin
            filt_w = r_acc[34:15];
        end else if (r_acc[ACC_W-1]) begin
            filt_w = 20'sh80000;
        end else begin
            filt_w = 20'sh7FFFF;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_take) n_state = S_SCALE;
            S_SCALE: n_state = S_MUL81;
            S_MUL81: n_state = S_SLOPE;
            S_SLOPE: n_state = S_NUMER;
            S_NUMER: n_state = S_MUL2;
            S_MUL2:  n_state = S_RAW;
            S_RAW:   n_state = S_FIR;
            S_FIR:   if (r_k == K_W'(LAST_K)) n_state = S_DONE;
            S_DONE:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Control and carried state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_wptr      <= '0;
            r_rd_vld    <= 1'b0;
            r_mul_vld   <= 1'b0;
            r_out_valid <= 1'b0;
            r_last      <= '0;
            r_run_mean  <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_rd_vld    <= fir_issue;
            r_mul_vld   <= r_rd_vld;
            if (r_state == S_FIR) begin
                r_k <= r_k + K_W'(1);
            end else begin
                r_k <= '0;
            end
            if (out_load) begin
                r_wptr <= r_wptr + HIST_AW'(1);
            end
            if (in_take) begin
                r_last     <= i_sensor_volts;
                r_run_mean <= mean_sum[21:1];
            end
        end
    end

    // Valid bits of both memories
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_set <= '0;
            r_hist_set <= '0;
        end else begin
            if (cfg_we) begin
                r_coef_set[cfg_addr] <= 1'b1;
            end
            if (hist_we) begin
                r_hist_set[r_wptr] <= 1'b1;
            end
        end
    end

    // Coefficient memory
    always_ff @(posedge i_clk) begin
        if (cfg_we) begin
            r_coef_mem[cfg_addr] <= i_cfg_data;
        end
        r_coef_rd <= r_coef_mem[coef_addr];
        r_coef_ok <= r_coef_set[coef_addr];
    end

    // Gap history memory, circular; newest entry at r_wptr
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist_mem[r_wptr] <= raw_clamp;
        end
        r_hist_rd <= r_hist_mem[hist_addr];
        r_hist_ok <= r_hist_set[hist_addr];
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cur  <= cur_w;
            r_diff <= {i_sensor_volts[15], i_sensor_volts} - {r_last[15], r_last};
        end
        if (r_state == S_SCALE) begin
            r_b81   <= b81_sum[27:0];
            r_dterm <= $signed({{17{r_diff[16]}}, r_diff}) * 34'sd50000;
        end
        if (r_state == S_MUL81) begin
            r_p81 <= r_b81 * RECIP_81;
        end
        if (r_state == S_SLOPE) begin
            if (slope_sum[34:31] != {4{slope_sum[31]}}) begin
                r_slope <= slope_sum[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                r_slope <= slope_sum[31:0];
            end
        end
        if (r_state == S_NUMER) begin
            r_b2 <= {mag_clip, 10'd0} + BIAS_2125;
        end
        if (r_state == S_MUL2) begin
            r_p2 <= r_b2 * RECIP_2125;
        end
        if (r_state == S_RAW) begin
            r_raw <= raw_clamp;
        end
        if (r_rd_vld) begin
            r_prod <= coef_op * hist_op;
        end
        if (r_state == S_RAW) begin
            r_acc <= '0;
        end else if (r_mul_vld) begin
            r_acc <= r_acc + {{(ACC_W-34){r_prod[33]}}, r_prod};
        end
        if (out_load) begin
            o_coil_current      <= r_cur;
            o_mean_current      <= r_run_mean;
            o_slope_value       <= r_slope;
            o_raw_position      <= r_raw;
            o_filtered_position <= filt_w;
        end
    end

endmodule
